@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/lge_pkg.sv @@
package lge_pkg;

   // Default grid size.
   localparam int GRID_ROWS_DEF = 32;
   localparam int GRID_COLS_DEF = 32;

   // Fixed field widths of the request and response words.
   localparam int OP_W  = 2;
   localparam int ROW_W = 5;
   localparam int COL_W = 5;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

   // Response kinds.
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // Neighbour counts that matter to the B3/S23 rule.
   localparam logic [3:0] SURVIVE_CNT = 4'd2;
   localparam logic [3:0] BIRTH_CNT   = 4'd3;

endpackage

@@ hdl/lge_row_ram.sv @@
// Simple dual-port row memory: one write port, one read port with registered data.
module lge_row_ram
   import lge_pkg::*;
#(
   parameter int DATA_W = GRID_COLS_DEF,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lge_cell_rule.sv @@
// Counts the eight neighbours of one cell and applies the B3/S23 rule.
module lge_cell_rule
   import lge_pkg::*;
(
   input  logic [7:0] nbr,
   input  logic       centre,
   output logic       alive
);

   logic [3:0] count;

   // Population count of the neighbour bits.
   always_comb begin
      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + 4'(nbr[i]);
      end
   end

   // A live cell survives on two or three, a dead one is born on three.
   assign alive = (count == BIRTH_CNT) || (centre && (count == SURVIVE_CNT));

endmodule

@@ hdl/life_generation_engine_unit.sv @@
// Game of Life engine (rule B3/S23, dead edges, no wrap). The grid is stored one row per
// memory word in two banks; a generation step reads the current bank, builds each new row
// one cell per cycle from a three-row window and writes it to the other bank, then swaps
// banks. After reset a clearing pass over the rows of bank 0 keeps busy high. A cell write
// or read first reads the row, then modifies and writes it back (write) or registers the
// read word (read). A step loads the first two rows, then for each row scans it cell by
// cell, writes it back and fetches the next row. There is exactly one response word per
// read or step, shown for one cycle on rsp_valid; the receiver cannot stall it, so it must
// take the word in that cycle.
`include "assert_macros.svh"

module life_generation_engine_unit
   import lge_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_op,
   input  logic [ROW_W-1:0] req_row,
   input  logic [COL_W-1:0] req_col,
   input  logic             req_cell_in,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic             rsp_cell_out
);

   localparam int RW = $clog2(GRID_ROWS);
   localparam int CW = $clog2(GRID_COLS);
   localparam int AW = RW + 1;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_ACCESS = 8'b0000_0100,
      S_LOAD0  = 8'b0000_1000,
      S_LOAD1  = 8'b0001_0000,
      S_SCAN   = 8'b0010_0000,
      S_WB     = 8'b0100_0000,
      S_FETCH  = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic                   bank_ff, bank_in;
   logic [RW-1:0]          row_cnt_ff, row_cnt_in;
   logic [CW-1:0]          col_cnt_ff, col_cnt_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [RW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic                   cell_ff, cell_in;
   logic                   on_grid_ff, on_grid_in;
   logic [GRID_COLS-1:0]   prev_ff, prev_in;
   logic [GRID_COLS-1:0]   cur_ff, cur_in;
   logic [GRID_COLS-1:0]   nxt_ff, nxt_in;
   logic                   lt_ff, lt_in;
   logic                   lm_ff, lm_in;
   logic                   lb_ff, lb_in;
   logic [GRID_COLS-1:0]   new_row_ff, new_row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_cell_ff, rsp_cell_in;

   logic                   accept;
   logic                   req_on_grid;
   logic                   last_col;
   logic                   last_row;
   logic [RW-1:0]          rd_row;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [GRID_COLS-1:0]   wr_data;
   logic [GRID_COLS-1:0]   rd_data;
   logic [GRID_COLS-1:0]   mod_row;
   logic [7:0]             nbr;
   logic                   alive;

   assign accept      = start && (state_ff == S_IDLE);
   assign req_on_grid = (int'(req_row) < GRID_ROWS) && (int'(req_col) < GRID_COLS);
   assign last_col    = (col_cnt_ff == CW'(GRID_COLS - 1));
   assign last_row    = (row_cnt_ff == RW'(GRID_ROWS - 1));

   // Row store, two banks selected by the top address bit.
   lge_row_ram #(
      .DATA_W (GRID_COLS),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr ({bank_ff, rd_row}),
      .rd_data (rd_data)
   );

   // Neighbour window: bit 0 of each row register is the current column.
   assign nbr = {lt_ff, lm_ff, lb_ff, prev_ff[0], nxt_ff[0],
                 prev_ff[1] && !last_col, cur_ff[1] && !last_col, nxt_ff[1] && !last_col};

   lge_cell_rule u_rule (
      .nbr    (nbr),
      .centre (cur_ff[0]),
      .alive  (alive)
   );

   // Single-cell write merges the new bit into the row just read.
   always_comb begin
      mod_row         = rd_data;
      mod_row[col_ff] = cell_ff;
   end

   // Read address for each state.
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_row = (req_op == OP_STEP) ? '0 : RW'(req_row);
         S_LOAD0: rd_row = RW'(1);
         S_WB:    rd_row = RW'(row_cnt_ff + RW'(2));
         default: rd_row = row_ff;
      endcase
   end

   // Write port: clearing pass, cell write-back, or new row to the other bank.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {bank_ff, row_cnt_ff};
      wr_data = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_ACCESS: begin
            wr_en   = (op_ff == OP_WRITE) && on_grid_ff;
            wr_addr = {bank_ff, row_ff};
            wr_data = mod_row;
         end
         S_WB: begin
            wr_en   = 1'b1;
            wr_addr = {!bank_ff, row_cnt_ff};
            wr_data = new_row_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cell_in      = cell_ff;
      on_grid_in   = on_grid_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      lt_in        = lt_ff;
      lm_in        = lm_ff;
      lb_in        = lb_ff;
      new_row_in   = new_row_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cell_in  = rsp_cell_ff;
      case (state_ff)
         S_CLEAR: begin
            row_cnt_in = RW'(row_cnt_ff + RW'(1));
            if (last_row) begin
               row_cnt_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               row_in     = RW'(req_row);
               col_in     = CW'(req_col);
               cell_in    = req_cell_in;
               on_grid_in = req_on_grid;
               row_cnt_in = '0;
               case (req_op)
                  OP_WRITE, OP_READ: state_in = S_ACCESS;
                  OP_STEP:           state_in = S_LOAD0;
                  default:           state_in = S_IDLE;
               endcase
            end
         end
         S_ACCESS: begin
            if (op_ff == OP_READ) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_READ;
               rsp_cell_in  = on_grid_ff && rd_data[col_ff];
            end
            state_in = S_IDLE;
         end
         S_LOAD0: begin
            prev_in  = '0;
            cur_in   = rd_data;
            state_in = S_LOAD1;
         end
         S_LOAD1: begin
            nxt_in     = rd_data;
            col_cnt_in = '0;
            lt_in      = 1'b0;
            lm_in      = 1'b0;
            lb_in      = 1'b0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            // Rotate the window one column and collect the new cell.
            new_row_in = {alive, new_row_ff[GRID_COLS-1:1]};
            lt_in      = prev_ff[0];
            lm_in      = cur_ff[0];
            lb_in      = nxt_ff[0];
            prev_in    = {prev_ff[0], prev_ff[GRID_COLS-1:1]};
            cur_in     = {cur_ff[0], cur_ff[GRID_COLS-1:1]};
            nxt_in     = {nxt_ff[0], nxt_ff[GRID_COLS-1:1]};
            col_cnt_in = CW'(col_cnt_ff + CW'(1));
            if (last_col) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            prev_in = cur_ff;
            cur_in  = nxt_ff;
            if (last_row) begin
               bank_in      = !bank_ff;
               row_cnt_in   = '0;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_STEP;
               rsp_cell_in  = 1'b0;
               state_in     = S_IDLE;
            end else begin
               row_cnt_in = RW'(row_cnt_ff + RW'(1));
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            // Below the last row the window sees dead cells.
            nxt_in     = last_row ? '0 : rd_data;
            col_cnt_in = '0;
            lt_in      = 1'b0;
            lm_in      = 1'b0;
            lb_in      = 1'b0;
            state_in   = S_SCAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         bank_ff      <= 1'b0;
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cell_ff     <= cell_in;
      on_grid_ff  <= on_grid_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      lt_ff       <= lt_in;
      lm_ff       <= lm_in;
      lb_ff       <= lb_in;
      new_row_ff  <= new_row_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_cell_out = rsp_cell_ff;

   // Checks on the sequencer.
   `ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid_ff, !rsp_valid_ff, "response word held for more than one cycle")
   `ASSERT_NEXT(a_write_no_rsp, clock, reset, (state_ff == S_ACCESS) && (op_ff == OP_WRITE), !rsp_valid_ff, "cell write produced a response word")
   `ASSERT_NEXT(a_step_busy, clock, reset, accept && (req_op == OP_STEP), busy && !rsp_valid_ff, "step did not hold busy")
   `ASSERT_NEXT(a_scan_wb, clock, reset, (state_ff == S_SCAN) && last_col, state_ff == S_WB, "row scan did not end in write-back")
   `ASSERT_SAME(a_step_rsp_kind, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_STEP), !rsp_cell_ff, "step response carries a cell value")

endmodule
